// ===== src/mgdm_pkg.sv =====
package mgdm_pkg;

	localparam int MaskOrderDefault = 2;
	localparam int ByteW            = 8;
	localparam int ShareFieldW      = 24;
	localparam int RndFieldW        = 48;
	localparam logic [ByteW-1:0] FieldPolyLow = 8'h1B;

	function automatic logic [ByteW-1:0] gf_mul(input logic [ByteW-1:0] x,
			input logic [ByteW-1:0] y);
		logic [ByteW-1:0] acc;
		logic [ByteW-1:0] p;
		acc = '0;
		p   = x;
		for (int k = 0; k < ByteW; k++) begin
			if (y[k]) begin
				acc = acc ^ p;
			end
			p = p[ByteW-1] ? ({p[ByteW-2:0], 1'b0} ^ FieldPolyLow) : {p[ByteW-2:0], 1'b0};
		end
		return acc;
	endfunction

endpackage

// ===== src/mgdm_gadget.sv =====
module mgdm_gadget import mgdm_pkg::*; #(
	parameter int MASK_ORDER = MaskOrderDefault
) (
	input  logic [ShareFieldW-1:0] a_shares,
	input  logic [ShareFieldW-1:0] b_shares,
	input  logic [RndFieldW-1:0]   rnd_bits,
	output logic [ShareFieldW-1:0] c_shares
);

	localparam int NumShares = MASK_ORDER + 1;

	always_comb begin
		logic [ByteW-1:0] opened;
		logic [ByteW-1:0] s;
		int lo;
		int hi;
		opened   = '0;
		c_shares = '0;
		for (int i = 0; i < NumShares; i++) begin
			opened = opened ^ b_shares[ByteW*i +: ByteW] ^ rnd_bits[ByteW*i +: ByteW];
		end
		for (int i = 0; i < NumShares; i++) begin
			s = gf_mul(a_shares[ByteW*i +: ByteW], rnd_bits[ByteW*i +: ByteW]);
			for (int j = 0; j < NumShares; j++) begin
				lo = (i < j) ? i : j;
				hi = (i < j) ? j : i;
				if (j != i) begin
					s = s ^ gf_mul(a_shares[ByteW*i +: ByteW], rnd_bits[ByteW*j +: ByteW])
						^ rnd_bits[ByteW*(NumShares + lo + hi*(hi-1)/2) +: ByteW];
				end
			end
			s = s ^ gf_mul(a_shares[ByteW*i +: ByteW], opened);
			c_shares[ByteW*i +: ByteW] = s;
		end
	end

endmodule

// ===== src/masked_gf256_dom_dep_multiply_core.sv =====
// channel  | ports                                   | handshake
// request  | a_shares, b_shares, rnd_bits            | start, accepted when busy is low
// result   | c_shares                                | done, one-cycle strobe
//
// an accepted request passes the stage-one register, then the result register, before its done strobe
// one request per cycle, path is one gf(2^8) gadget between two registers
// busy stays low, the pipeline never holds a request back
// arst_n clears the valid flags only; results are not stalled by the receiver
module masked_gf256_dom_dep_multiply_core import mgdm_pkg::*; #(
	parameter int MASK_ORDER = MaskOrderDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [ShareFieldW-1:0] a_shares,
	input  logic [ShareFieldW-1:0] b_shares,
	input  logic [RndFieldW-1:0]   rnd_bits,
	output logic                   done,
	output logic [ShareFieldW-1:0] c_shares
);

	logic                   valid_s1;
	logic [ShareFieldW-1:0] a_s1;
	logic [ShareFieldW-1:0] b_s1;
	logic [RndFieldW-1:0]   rnd_s1;
	logic                   valid_s2;
	logic [ShareFieldW-1:0] c_s2;
	logic [ShareFieldW-1:0] c_comb;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			a_s1   <= a_shares;
			b_s1   <= b_shares;
			rnd_s1 <= rnd_bits;
		end
		if (valid_s1) begin
			c_s2 <= c_comb;
		end
	end

	mgdm_gadget #(
		.MASK_ORDER(MASK_ORDER)
	) u_gadget (
		.a_shares(a_s1),
		.b_shares(b_s1),
		.rnd_bits(rnd_s1),
		.c_shares(c_comb)
	);

	assign done     = valid_s2;
	assign c_shares = c_s2;

`ifndef NO_ASSERTIONS
	a_req_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("request in stage one did not reach the result register");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> !done)
		else $error("done raised without a request in stage one");

	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> valid_s1)
		else $error("accepted request not captured");
`endif

endmodule

// ===== tb/tb_masked_gf256_dom_dep_multiply_core.sv =====
`timescale 1ns / 1ps

module tb_masked_gf256_dom_dep_multiply_core;
	import mgdm_pkg::*;

	localparam int MaskOrder  = MaskOrderDefault;
	localparam int NumShares  = MaskOrder + 1;
	localparam int CycleLimit = 200000;
	localparam int DrainWait  = 6;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [ShareFieldW-1:0] a_shares;
	logic [ShareFieldW-1:0] b_shares;
	logic [RndFieldW-1:0]   rnd_bits;
	logic                   done;
	logic [ShareFieldW-1:0] c_shares;

	int cycle_count;

	masked_gf256_dom_dep_multiply_core #(
		.MASK_ORDER(MaskOrder)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.a_shares (a_shares),
		.b_shares (b_shares),
		.rnd_bits (rnd_bits),
		.done     (done),
		.c_shares (c_shares)
	);

	class product_scoreboard;
		logic [ShareFieldW-1:0] expected_products[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// horner form, msb of y first
		function logic [ByteW-1:0] field_product(logic [ByteW-1:0] x, logic [ByteW-1:0] y);
			logic [ByteW-1:0] acc;
			acc = '0;
			for (int k = ByteW - 1; k >= 0; k--) begin
				acc = {acc[ByteW-2:0], 1'b0} ^ (acc[ByteW-1] ? 8'h1B : 8'h00);
				if (y[k]) begin
					acc = acc ^ x;
				end
			end
			return acc;
		endfunction

		function void note_request(logic [ShareFieldW-1:0] a, logic [ShareFieldW-1:0] b,
				logic [RndFieldW-1:0] r);
			logic [ByteW-1:0]       opened;
			logic [ByteW-1:0]       share;
			logic [ByteW-1:0]       a_i;
			logic [ShareFieldW-1:0] product;
			int                     lo;
			int                     hi;
			opened  = '0;
			product = '0;
			for (int i = 0; i < NumShares; i++) begin
				opened = opened ^ b[8*i +: 8] ^ r[8*i +: 8];
			end
			for (int i = 0; i < NumShares; i++) begin
				a_i   = a[8*i +: 8];
				share = field_product(a_i, r[8*i +: 8]);
				for (int j = 0; j < NumShares; j++) begin
					if (j != i) begin
						lo    = (i < j) ? i : j;
						hi    = (i < j) ? j : i;
						share = share ^ field_product(a_i, r[8*j +: 8])
							^ r[8*(NumShares + lo + hi*(hi-1)/2) +: 8];
					end
				end
				share = share ^ field_product(a_i, opened);
				product[8*i +: 8] = share;
			end
			expected_products.push_back(product);
		endfunction

		function void check_result(logic [ShareFieldW-1:0] c);
			logic [ShareFieldW-1:0] want;
			if (expected_products.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h", $time, c);
				errors++;
			end else begin
				want = expected_products.pop_front();
				if (c !== want) begin
					$display("%0t: c_shares expected %h actual %h", $time, want, c);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_products.size();
		endfunction
	endclass

	product_scoreboard sb;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.note_request(a_shares, b_shares, rnd_bits);
			end
			if (done) begin
				sb.check_result(c_shares);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_request(logic [ShareFieldW-1:0] a, logic [ShareFieldW-1:0] b,
			logic [RndFieldW-1:0] r);
		start    <= 1'b1;
		a_shares <= a;
		b_shares <= b;
		rnd_bits <= r;
		do begin
			@(posedge clk);
		end while (busy);
	endtask

	task automatic idle_sender(int idle_pct);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start    <= 1'b0;
			a_shares <= ShareFieldW'($urandom);
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) begin
				@(posedge clk);
			end
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic run_random(int count, int idle_pct);
		logic [ShareFieldW-1:0] a;
		logic [ShareFieldW-1:0] b;
		logic [RndFieldW-1:0]   r;
		for (int n = 0; n < count; n++) begin
			a = ShareFieldW'($urandom);
			b = ShareFieldW'($urandom);
			r = {16'($urandom), 32'($urandom)};
			// zero factors and zero shares now and then
			case ($urandom_range(19))
				0: a = '0;
				1: b = '0;
				2: a[8*$urandom_range(NumShares-1) +: 8] = '0;
				3: r[8*$urandom_range(NumShares-1) +: 8] = '0;
				4: b = ShareFieldW'({NumShares{8'($urandom_range(255))}}) ^ a;
				default: ;
			endcase
			send_request(a, b, r);
			idle_sender(idle_pct);
		end
	endtask

	initial begin
		sb          = new();
		cycle_count = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		a_shares    = '0;
		b_shares    = '0;
		rnd_bits    = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, zero factors, single bits in each share
		send_request('0, '0, '0);
		send_request('1, '1, '1);
		send_request('1, '0, '0);
		send_request('0, '1, '1);
		send_request('1, '1, '0);
		send_request(24'h000001, 24'h000001, '0);
		send_request(24'h800000, 24'h008000, 48'h800000000000);
		send_request(24'h808080, 24'h010101, 48'h010203040506);
		send_request(24'h020202, 24'h808080, 48'hFFFFFFFFFF00);
		send_request(24'h53CA00, 24'h00CA53, 48'h00FF00FF00FF);
		send_request(24'hFF00FF, 24'h00FF00, 48'hFF00FF00FF00);
		send_request(24'h123456, 24'h123456, 48'h123456123456);
		send_request(24'h5A5A5A, 24'hA5A5A5, 48'hA5A5A5A5A5A5);
		send_request(24'h8D8D8D, 24'hF6F6F6, 48'h000000000000);
		send_request(24'h010000, 24'h000100, 48'h000000010000);
		send_request(24'hFFFFFF, 24'h7F7F7F, 48'hFEFEFEFEFEFE);
		drain_results();

		run_random(383, 0);
		drain_results();
		run_random(383, 49);
		drain_results();
		repeat (DrainWait) @(posedge clk);
		run_random(383, 0);
		drain_results();
		run_random(385, 32);
		drain_results();
		repeat (DrainWait) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== masked_gf256_dom_dep_multiply_core.f =====
src/mgdm_pkg.sv
src/mgdm_gadget.sv
src/masked_gf256_dom_dep_multiply_core.sv
tb/tb_masked_gf256_dom_dep_multiply_core.sv
